@@ rtl/ilop_pkg.sv @@
// Shared types, constants and decode functions of the instruction length and opcode predecoder.
package ilop_pkg;

   // Fixed field widths.
   localparam int BUF_BITS     = 48;
   localparam int OFS_OUT_BITS = 32;
   localparam int OPCODE_BITS  = 16;
   localparam int LEN_BITS     = 3;
   localparam int RSP_DATA_BITS = 104;

   // Defaults for the top-level parameters.
   localparam int OFFSET_BITS_DEF = 32;
   localparam int QUEUE_DEPTH_DEF = 2;

   // Instruction lengths in bytes.
   localparam logic [LEN_BITS-1:0] LEN_NONE = 3'd0;
   localparam logic [LEN_BITS-1:0] LEN_TWO  = 3'd2;
   localparam logic [LEN_BITS-1:0] LEN_FOUR = 3'd4;
   localparam logic [LEN_BITS-1:0] LEN_SIX  = 3'd6;

   // First-byte values that select an extended opcode form.
   localparam logic [7:0] FB_01 = 8'h01;
   localparam logic [7:0] FB_A5 = 8'hA5;
   localparam logic [7:0] FB_A7 = 8'hA7;
   localparam logic [7:0] FB_B2 = 8'hB2;
   localparam logic [7:0] FB_B3 = 8'hB3;
   localparam logic [7:0] FB_B9 = 8'hB9;
   localparam logic [7:0] FB_C0 = 8'hC0;
   localparam logic [7:0] FB_C2 = 8'hC2;
   localparam logic [7:0] FB_C4 = 8'hC4;
   localparam logic [7:0] FB_C6 = 8'hC6;
   localparam logic [7:0] FB_C8 = 8'hC8;
   localparam logic [7:0] FB_CC = 8'hCC;
   localparam logic [7:0] FB_E3 = 8'hE3;
   localparam logic [7:0] FB_E5 = 8'hE5;
   localparam logic [7:0] FB_E6 = 8'hE6;
   localparam logic [7:0] FB_E7 = 8'hE7;
   localparam logic [7:0] FB_EB = 8'hEB;
   localparam logic [7:0] FB_EC = 8'hEC;
   localparam logic [7:0] FB_ED = 8'hED;

   // One gathered instruction, handed from the gather stage to the decode stage.
   typedef struct packed {
      logic [BUF_BITS-1:0]     bits;
      logic [LEN_BITS-1:0]     len;
      logic [OFS_OUT_BITS-1:0] offset;
      logic                    truncated;
   } instr_type;

   // Instruction length from the high nibble of the first byte.
   function automatic logic [LEN_BITS-1:0] length_of(input logic [7:0] first);
      logic [LEN_BITS-1:0] len;
      case (first[7:4]) inside
         [4'h0:4'h3]: len = LEN_TWO;
         [4'h4:4'hB]: len = LEN_FOUR;
         default:     len = LEN_SIX;
      endcase
      return len;
   endfunction

   // Opcode extraction; the first byte and the length pick the form.
   function automatic logic [OPCODE_BITS-1:0] decode_opcode(input logic [BUF_BITS-1:0] bits,
                                                            input logic [LEN_BITS-1:0] len);
      logic [7:0]             b0;
      logic [7:0]             b1;
      logic [7:0]             b5;
      logic [OPCODE_BITS-1:0] op;
      b0 = bits[47:40];
      b1 = bits[39:32];
      b5 = bits[7:0];
      op = {8'h00, b0};
      case (len)
         LEN_SIX: begin
            case (b0) inside
               FB_E3, FB_E6, FB_E7, FB_EB, FB_EC, FB_ED: op = {b0, b5};
               FB_E5:                                    op = {b0, b1};
               FB_C0, FB_C2, FB_C4, FB_C6, FB_C8, FB_CC: op = {4'h0, b0, b1[3:0]};
               default:                                  op = {8'h00, b0};
            endcase
         end
         LEN_FOUR: begin
            case (b0) inside
               FB_B2, FB_B3, FB_B9: op = {b0, b1};
               FB_A5, FB_A7:        op = {4'h0, b0, b1[3:0]};
               default:             op = {8'h00, b0};
            endcase
         end
         default: begin
            if (b0 == FB_01) begin
               op = {b0, b1};
            end
         end
      endcase
      return op;
   endfunction

endpackage

@@ rtl/instruction_length_opcode_predecoder.sv @@
// Top level of the instruction length and opcode predecoder.
// The block takes one machine-code byte per cycle on the req_ channel while the queue has
// room, and emits one rsp_ transaction per instruction once its last byte has arrived,
// or early with the truncated flag set when the byte marked by req_tlast ends the stream
// mid-instruction. A finished instruction is written into the queue as its last byte is
// taken; the gather stage registers partial instructions, the decode stage results, and
// a queue of QUEUE_DEPTH entries between them absorbs backpressure, so bytes keep flowing
// at one per cycle while rsp_tready is held high. After a stream end the offset counter
// and the gather state start over from zero. The offset counter is OFFSET_BITS wide and
// wraps; the result carries its low 32 bits.
module instruction_length_opcode_predecoder
   import ilop_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,  // data_byte [7:0]
   input  logic                     req_tlast,  // stream_end
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // opcode_value [15:0], length_bytes [18:16], byte_offset [50:19],
   // instruction_bits [98:51], zero fill [103:99]
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                     rsp_tuser   // truncated
);

   logic                    push_valid;
   logic                    push_ready;
   instr_type               push_data;
   logic                    pop_valid;
   logic                    pop_ready;
   instr_type               pop_data;
   logic [OPCODE_BITS-1:0]  rsp_opcode;
   logic [LEN_BITS-1:0]     rsp_len;
   logic [OFS_OUT_BITS-1:0] rsp_offset;
   logic [BUF_BITS-1:0]     rsp_bits;

   ilop_gather #(
      .OFFSET_BITS(OFFSET_BITS)
   ) u_gather (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .in_last    (req_tlast),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   ilop_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   ilop_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_data      (pop_data),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_opcode    (rsp_opcode),
      .out_len       (rsp_len),
      .out_offset    (rsp_offset),
      .out_bits      (rsp_bits),
      .out_truncated (rsp_tuser)
   );

   // Pack the result fields, lowest field first, zero-filled to whole bytes.
   assign rsp_tdata = {5'b00000, rsp_bits, rsp_offset, rsp_len, rsp_opcode};

endmodule

@@ rtl/ilop_gather.sv @@
// Front stage: accepts stream bytes, gathers them into instructions and tracks the offset.
module ilop_gather
   import ilop_pkg::*;
#(
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  logic [7:0] in_byte,
   input  logic      in_last,
   output logic      push_valid,
   input  logic      push_ready,
   output instr_type push_data
);

   logic [BUF_BITS-1:0]     buf_ff, buf_in;
   logic [LEN_BITS-1:0]     held_ff, held_in;
   logic [LEN_BITS-1:0]     exp_ff, exp_in;
   logic [OFFSET_BITS-1:0]  start_ff, start_in;
   logic [OFS_OUT_BITS-1:0] start_out;
   logic [BUF_BITS-1:0]     buf_new;
   logic [LEN_BITS-1:0]     held_new;
   logic [LEN_BITS-1:0]     exp_new;
   logic                    accept;
   logic                    done;

   // A byte is taken only when the queue can hold a possible finished instruction.
   assign in_ready = push_ready;
   assign accept   = in_valid && in_ready;

   // Low bits of the offset counter, zero-extended where the counter is narrow.
   generate
      if (OFFSET_BITS >= OFS_OUT_BITS) begin : g_ofs_trunc
         assign start_out = start_ff[OFS_OUT_BITS-1:0];
      end else begin : g_ofs_ext
         assign start_out = {{(OFS_OUT_BITS-OFFSET_BITS){1'b0}}, start_ff};
      end
   endgenerate

   // Insert the byte at its lane and check for a complete instruction.
   always_comb begin
      if (held_ff == 3'd0) begin
         exp_new = length_of(in_byte);
         buf_new = '0;
      end else begin
         exp_new = exp_ff;
         buf_new = buf_ff;
      end
      held_new = held_ff;
      if (held_ff < LEN_SIX) begin
         for (int i = 0; i < 6; i++) begin
            if (held_ff == LEN_BITS'(i)) begin
               buf_new[BUF_BITS-1-8*i -: 8] = in_byte;
            end
         end
         held_new = held_ff + 3'd1;
      end
      done = held_new >= exp_new;
   end

   // Finished or cut-short instruction goes to the queue.
   assign push_valid          = accept && (done || in_last);
   assign push_data.bits      = buf_new;
   assign push_data.len       = exp_new;
   assign push_data.offset    = start_out;
   assign push_data.truncated = !done;

   // Next state of the gather registers.
   always_comb begin
      buf_in   = buf_ff;
      held_in  = held_ff;
      exp_in   = exp_ff;
      start_in = start_ff;
      if (accept) begin
         if (in_last) begin
            buf_in   = '0;
            held_in  = 3'd0;
            exp_in   = LEN_NONE;
            start_in = '0;
         end else if (done) begin
            buf_in   = '0;
            held_in  = 3'd0;
            exp_in   = LEN_NONE;
            start_in = start_ff + OFFSET_BITS'(exp_new);
         end else begin
            buf_in  = buf_new;
            held_in = held_new;
            exp_in  = exp_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_ff   <= '0;
         held_ff  <= 3'd0;
         exp_ff   <= LEN_NONE;
         start_ff <= '0;
      end else begin
         buf_ff   <= buf_in;
         held_ff  <= held_in;
         exp_ff   <= exp_in;
         start_ff <= start_in;
      end
   end

endmodule

@@ rtl/ilop_queue.sv @@
// Short queue of gathered instructions between the gather and decode stages.
module ilop_queue
   import ilop_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  instr_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output instr_type out_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   instr_type           slot_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push;
   logic                pop;

   assign in_ready  = count_ff != CNT_BITS'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill-count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

@@ rtl/ilop_decode.sv @@
// Back stage: extracts the opcode and holds the result transaction in the output register.
module ilop_decode
   import ilop_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     pop_valid,
   output logic                     pop_ready,
   input  instr_type                pop_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [OPCODE_BITS-1:0]   out_opcode,
   output logic [LEN_BITS-1:0]      out_len,
   output logic [OFS_OUT_BITS-1:0]  out_offset,
   output logic [BUF_BITS-1:0]      out_bits,
   output logic                     out_truncated
);

   logic                    valid_ff, valid_in;
   logic [OPCODE_BITS-1:0]  opcode_ff;
   logic [LEN_BITS-1:0]     len_ff;
   logic [OFS_OUT_BITS-1:0] offset_ff;
   logic [BUF_BITS-1:0]     bits_ff;
   logic                    trunc_ff;
   logic                    load;

   // The output register takes a new entry when empty or being drained.
   assign pop_ready = !valid_ff || out_ready;
   assign load      = pop_valid && pop_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (load) begin
         opcode_ff <= decode_opcode(pop_data.bits, pop_data.len);
         len_ff    <= pop_data.len;
         offset_ff <= pop_data.offset;
         bits_ff   <= pop_data.bits;
         trunc_ff  <= pop_data.truncated;
      end
   end

   assign out_valid     = valid_ff;
   assign out_opcode    = opcode_ff;
   assign out_len       = len_ff;
   assign out_offset    = offset_ff;
   assign out_bits      = bits_ff;
   assign out_truncated = trunc_ff;

endmodule

@@ sim/instruction_length_opcode_predecoder_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the instruction length and opcode predecoder.
module instruction_length_opcode_predecoder_tb
   import ilop_pkg::*;
();

   localparam int OFFSET_WIDTH     = OFFSET_BITS_DEF;
   localparam int STALL_LIMIT      = 2000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int DRAIN_CYCLES     = 10;
   localparam int MAX_REPORTS      = 10;
   localparam int DIRECTED_ROWS    = 25;

   // First bytes that select an opcode wider than the first byte alone.
   localparam logic [18:0][7:0] EXTENDED_FIRSTS = {
      FB_01, FB_A5, FB_A7, FB_B2, FB_B3, FB_B9, FB_C0, FB_C2, FB_C4, FB_C6,
      FB_C8, FB_CC, FB_E3, FB_E5, FB_E6, FB_E7, FB_EB, FB_EC, FB_ED};

   // Where the opcode bits beyond the first byte come from.
   typedef enum logic [1:0] {
      OPC_FIRST_BYTE,
      OPC_WITH_SECOND,
      OPC_WITH_SIXTH,
      OPC_WITH_NIBBLE
   } opcode_form_type;

   // One decoded instruction as it leaves the block.
   typedef struct packed {
      logic [OPCODE_BITS-1:0]  opcode;
      logic [LEN_BITS-1:0]     len;
      logic [OFS_OUT_BITS-1:0] offset;
      logic [BUF_BITS-1:0]     raw;
      logic                    truncated;
   } decoded_instr_type;

   // One row of the directed table; typed rows carry their expected decode.
   typedef struct packed {
      logic [7:0]        data;
      logic              stream_end;
      logic              typed;
      decoded_instr_type want;
   } stim_row_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata  = 8'h00;
   logic                     req_tlast  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tuser;

   // Stream gathering state of the predictor.
   logic [BUF_BITS-1:0]     gather_buf    = '0;
   logic [2:0]              gather_count  = '0;
   logic [LEN_BITS-1:0]     gather_len    = LEN_NONE;
   logic [OFFSET_WIDTH-1:0] gather_offset = '0;
   decoded_instr_type       expected_decodes[$];

   stim_row_type directed_rows [DIRECTED_ROWS];

   int  tx_idle_pct    = 20;
   int  rx_idle_pct    = 87;
   logic hold_request  = 1'b0;
   int  hold_left      = 0;
   int  bytes_sent     = 0;
   int  stream_ends    = 0;
   int  results_seen   = 0;
   int  truncated_seen = 0;
   int  six_byte_seen  = 0;
   int  mismatches     = 0;
   int  quiet_cycles   = 0;

   instruction_length_opcode_predecoder DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // The high nibble of the first byte fixes the instruction length.
   function automatic logic [LEN_BITS-1:0] size_from_first(input logic [7:0] first_byte);
      if (first_byte < 8'h40) return LEN_TWO;
      if (first_byte < 8'hC0) return LEN_FOUR;
      return LEN_SIX;
   endfunction

   // Every extended first byte implies its own length, so the byte alone picks the form.
   function automatic opcode_form_type form_of(input logic [7:0] first_byte);
      case (first_byte)
         FB_E3, FB_E6, FB_E7, FB_EB, FB_EC, FB_ED:        return OPC_WITH_SIXTH;
         FB_E5, FB_B2, FB_B3, FB_B9, FB_01:               return OPC_WITH_SECOND;
         FB_C0, FB_C2, FB_C4, FB_C6, FB_C8, FB_CC,
         FB_A5, FB_A7:                                    return OPC_WITH_NIBBLE;
         default:                                         return OPC_FIRST_BYTE;
      endcase
   endfunction

   function automatic logic [OPCODE_BITS-1:0] opcode_from(input logic [BUF_BITS-1:0] raw);
      logic [7:0] lead;
      lead = raw[47:40];
      case (form_of(lead))
         OPC_WITH_SIXTH:  return {lead, raw[7:0]};
         OPC_WITH_SECOND: return {lead, raw[39:32]};
         OPC_WITH_NIBBLE: return {4'h0, lead, raw[35:32]};
         default:         return {8'h00, lead};
      endcase
   endfunction

   // Folds one accepted byte into the gathered instruction and reports any decode it completes.
   task automatic absorb_byte(input logic [7:0] data, input logic end_flag,
                              output logic emitted, output decoded_instr_type decode);
      logic complete;
      if (gather_count == 0) begin
         gather_len = size_from_first(data);
         gather_buf = '0;
      end
      if (gather_count < 6) begin
         gather_buf   = gather_buf | (48'(data) << (40 - 8 * int'(gather_count)));
         gather_count = gather_count + 3'd1;
      end
      complete = (gather_count >= gather_len);
      emitted  = complete || end_flag;
      decode   = '0;
      if (emitted) begin
         decode.opcode    = opcode_from(gather_buf);
         decode.len       = gather_len;
         decode.offset    = gather_offset[OFS_OUT_BITS-1:0];
         decode.raw       = gather_buf;
         decode.truncated = !complete;
         // A stream end restarts the offset; otherwise it moves past this instruction.
         gather_offset = end_flag ? '0 : gather_offset + OFFSET_WIDTH'(gather_len);
         gather_buf    = '0;
         gather_count  = '0;
         gather_len    = LEN_NONE;
      end
   endtask

   // Offers one byte from a falling edge, waits for its transaction and records the expectation.
   task automatic send_byte(input logic [7:0] data, input logic end_flag, input logic typed,
                            input decoded_instr_type want);
      logic              emitted;
      decoded_instr_type decode;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= end_flag;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
      if (end_flag) stream_ends++;
      absorb_byte(data, end_flag, emitted, decode);
      if (typed) begin
         expected_decodes.push_back(want);
      end else if (emitted) begin
         expected_decodes.push_back(decode);
      end
      @(negedge clock);
   endtask

   // Mostly whole instructions with random operands, some ending or cutting the stream,
   // and now and then a burst of arbitrary bytes.
   task automatic send_random_segment();
      int         roll;
      int         len;
      int         cut;
      int         burst;
      logic [7:0] lead;
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         burst = $urandom_range(1, 8);
         for (int i = 0; i < burst; i++) begin
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0, 1'b0, '0);
         end
      end else begin
         if ($urandom_range(0, 1) == 1) begin
            lead = EXTENDED_FIRSTS[$urandom_range(0, 18)];
         end else begin
            lead = 8'($urandom_range(0, 255));
         end
         len  = int'(size_from_first(lead));
         roll = $urandom_range(0, 99);
         if (roll < 6) begin
            cut = len - 1;
         end else if (roll < 12) begin
            cut = $urandom_range(0, len - 2);
         end else begin
            cut = -1;
         end
         for (int i = 0; i < len; i++) begin
            send_byte((i == 0) ? lead : 8'($urandom_range(0, 255)), i == cut, 1'b0, '0);
            if (i == cut) break;
         end
      end
   endtask

   // Holds the sender off until every expected decode has come back; returns at a rising edge.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_decodes.size() != 0);
   endtask

   task automatic run_phase(input int tx_pct, input int rx_pct, input int count,
                            input logic long_hold);
      int start;
      tx_idle_pct  = tx_pct;
      rx_idle_pct  = rx_pct;
      hold_request = long_hold;
      @(negedge clock);
      start = bytes_sent;
      while (bytes_sent - start < count) send_random_segment();
      wait_drained();
   endtask

   // Receiver: random stalls, plus one long hold-off when asked for.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (hold_request) begin
            hold_left    = LONG_HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   // Compares one field and reports the first few differences.
   task automatic flag_field(input string field, input logic [63:0] want_v,
                             input logic [63:0] got_v);
      if (want_v !== got_v) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS) begin
            $display("result %0d: %s expected %h got %h", results_seen, field, want_v, got_v);
         end
      end
   endtask

   // Result checker: each rsp_ transaction against the oldest expected decode.
   always @(posedge clock) begin : result_monitor
      decoded_instr_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         if (rsp_tuser) truncated_seen++;
         if (rsp_tdata[18:16] == LEN_SIX) six_byte_seen++;
         if (expected_decodes.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("result %0d: unexpected transaction, data %h", results_seen, rsp_tdata);
            end
         end else begin
            want = expected_decodes.pop_front();
            flag_field("opcode", 64'(want.opcode), 64'(rsp_tdata[15:0]));
            flag_field("length", 64'(want.len), 64'(rsp_tdata[18:16]));
            flag_field("offset", 64'(want.offset), 64'(rsp_tdata[50:19]));
            flag_field("instruction bits", 64'(want.raw), 64'(rsp_tdata[98:51]));
            flag_field("fill", 64'(0), 64'(rsp_tdata[103:99]));
            flag_field("truncated", 64'(want.truncated), 64'(rsp_tuser));
         end
      end
   end

   // Watchdog on cycles without any transaction.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles = quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      // Directed table: lone truncated byte, the two-byte extended form, the four-byte
      // second-byte and cut nibble forms, the six-byte sixth-byte form, a complete all-ones
      // instruction closing the stream and a stream cut inside a six-byte instruction.
      directed_rows = '{
         '{8'h00, 1'b1, 1'b1, '{16'h0000, LEN_TWO, 32'd0, 48'h0000_0000_0000, 1'b1}},
         '{8'h01, 1'b0, 1'b0, '0},
         '{8'hFF, 1'b0, 1'b1, '{16'h01FF, LEN_TWO, 32'd0, 48'h01FF_0000_0000, 1'b0}},
         '{8'hB2, 1'b0, 1'b0, '0},
         '{8'h5A, 1'b0, 1'b0, '0},
         '{8'h12, 1'b0, 1'b0, '0},
         '{8'h34, 1'b0, 1'b0, '0},
         '{8'hA7, 1'b0, 1'b0, '0},
         '{8'h3C, 1'b1, 1'b0, '0},
         '{8'hE3, 1'b0, 1'b0, '0},
         '{8'h11, 1'b0, 1'b0, '0},
         '{8'h22, 1'b0, 1'b0, '0},
         '{8'h33, 1'b0, 1'b0, '0},
         '{8'h44, 1'b0, 1'b0, '0},
         '{8'h55, 1'b0, 1'b0, '0},
         '{8'hFF, 1'b0, 1'b0, '0},
         '{8'hFF, 1'b0, 1'b0, '0},
         '{8'hFF, 1'b0, 1'b0, '0},
         '{8'hFF, 1'b0, 1'b0, '0},
         '{8'hFF, 1'b0, 1'b0, '0},
         '{8'hFF, 1'b1, 1'b1, '{16'h00FF, LEN_SIX, 32'd6, 48'hFFFF_FFFF_FFFF, 1'b0}},
         '{8'h3F, 1'b0, 1'b0, '0},
         '{8'h80, 1'b0, 1'b0, '0},
         '{8'hC4, 1'b0, 1'b0, '0},
         '{8'hAB, 1'b1, 1'b0, '0}
      };

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int k = 0; k < DIRECTED_ROWS; k++) begin
         send_byte(directed_rows[k].data, directed_rows[k].stream_end,
                   directed_rows[k].typed, directed_rows[k].want);
      end
      wait_drained();

      // Sender idles lightly while the receiver mostly stalls, then the reverse,
      // then full rate behind one long receiver hold-off.
      run_phase(20, 87, 233, 1'b0);
      run_phase(87, 20, 233, 1'b0);
      run_phase(0, 0, 234, 1'b1);

      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes over %0d stream ends; checked %0d results.",
               bytes_sent, stream_ends, results_seen);
      $display("Of those, %0d were truncated and %0d were six-byte instructions.",
               truncated_seen, six_byte_seen);
      if (mismatches == 0 && expected_decodes.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         if (expected_decodes.size() != 0) begin
            $display("%0d expected results never arrived", expected_decodes.size());
         end
         $display("%0d mismatches", mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
